/* rtl/prqf_pkg.sv */
// Package for the paired read quality filter: sizes, character codes and beat types.
`default_nettype none
package prqf_pkg;

    localparam int MAX_READ_LEN = 512;
    localparam int LEN_W        = $clog2(MAX_READ_LEN + 1);
    localparam int OUT_LEN_W    = 10;
    localparam int QV_W         = 9;
    localparam int SUM_W        = LEN_W + QV_W;
    localparam int CFG_W        = 7;
    localparam int NUM_SYM      = 5;
    localparam int QDEPTH       = 4;
    localparam int QPTR_W       = $clog2(QDEPTH);
    localparam int QCNT_W       = $clog2(QDEPTH + 1);

    localparam int SYM_N = 0;
    localparam int SYM_A = 1;
    localparam int SYM_C = 2;
    localparam int SYM_G = 3;
    localparam int SYM_T = 4;

    localparam logic [7:0] CH_N   = 8'h4E;
    localparam logic [7:0] CH_A   = 8'h41;
    localparam logic [7:0] CH_C   = 8'h43;
    localparam logic [7:0] CH_G   = 8'h47;
    localparam logic [7:0] CH_T   = 8'h54;
    localparam logic [7:0] CH_DOT = 8'h2E;
    localparam logic [7:0] CH_B   = 8'h42;

    localparam logic [CFG_W-1:0] B_RULE_OFFSET   = 7'd64;
    localparam logic [QV_W-1:0]  B_QUALITY_VALUE = 9'd15;

    localparam logic [CFG_W-1:0] QUAL_OFFSET_RST = 7'd33;
    localparam logic [CFG_W-1:0] MIN_MEAN_RST    = 7'd20;

    localparam logic REG_QUAL_OFFSET = 1'b0;
    localparam logic REG_MIN_MEAN    = 1'b1;

    typedef struct packed {
        logic [7:0] fwd_base;
        logic [7:0] fwd_qual;
        logic [7:0] rev_base;
        logic [7:0] rev_qual;
        logic       last_position;
    } t_in_beat;

    typedef struct packed {
        logic                 reject;
        logic [OUT_LEN_W-1:0] read_length;
    } t_out_beat;

    typedef struct packed {
        logic [NUM_SYM-1:0]     fwd_sym;
        logic [NUM_SYM-1:0]     rev_sym;
        logic                   fwd_dot;
        logic                   rev_dot;
        logic signed [QV_W-1:0] fwd_q;
        logic signed [QV_W-1:0] rev_q;
        logic                   last;
    } t_cls;

    typedef struct packed {
        logic [NUM_SYM-1:0][LEN_W-1:0] fwd_cnt;
        logic [NUM_SYM-1:0][LEN_W-1:0] rev_cnt;
        logic signed [SUM_W-1:0]       fwd_sum;
        logic signed [SUM_W-1:0]       rev_sum;
        logic [LEN_W-1:0]              len;
        logic                          fwd_dot;
        logic                          rev_dot;
        logic                          ovf;
    } t_pair_stat;

endpackage
`default_nettype wire

/* rtl/prqf_front.sv */
// Front end: classifies one position beat into symbol flags and quality values.
`default_nettype none
module prqf_front
    import prqf_pkg::*;
(
    input  wire t_in_beat         i_beat,
    input  wire logic [CFG_W-1:0] i_qual_offset,
    output t_cls                  o_cls
);

    function automatic logic [NUM_SYM-1:0] sym_hot(input logic [7:0] ch);
        logic [NUM_SYM-1:0] h;
        h        = '0;
        h[SYM_N] = (ch == CH_N);
        h[SYM_A] = (ch == CH_A);
        h[SYM_C] = (ch == CH_C);
        h[SYM_G] = (ch == CH_G);
        h[SYM_T] = (ch == CH_T);
        return h;
    endfunction

    function automatic logic [QV_W-1:0] qual_val(input logic [7:0] q,
                                                 input logic [CFG_W-1:0] off);
        logic [QV_W-1:0] v;
        if (off == B_RULE_OFFSET && q == CH_B) begin
            v = B_QUALITY_VALUE;
        end else begin
            v = {1'b0, q} - {2'b00, off};
        end
        return v;
    endfunction

    always_comb begin
        o_cls.fwd_sym = sym_hot(i_beat.fwd_base);
        o_cls.rev_sym = sym_hot(i_beat.rev_base);
        o_cls.fwd_dot = (i_beat.fwd_base == CH_DOT);
        o_cls.rev_dot = (i_beat.rev_base == CH_DOT);
        o_cls.fwd_q   = qual_val(i_beat.fwd_qual, i_qual_offset);
        o_cls.rev_q   = qual_val(i_beat.rev_qual, i_qual_offset);
        o_cls.last    = i_beat.last_position;
    end

endmodule
`default_nettype wire

/* rtl/prqf_queue.sv */
// Short queue of classified beats between the front end and the back end.
`default_nettype none
module prqf_queue
    import prqf_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cls i_data,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_cls      o_data
);

    t_cls [QDEPTH-1:0] r_mem;
    logic [QPTR_W-1:0] r_wr, n_wr;
    logic [QPTR_W-1:0] r_rd, n_rd;
    logic [QCNT_W-1:0] r_cnt, n_cnt;

    always_comb begin
        n_wr  = i_push ? r_wr + 1'b1 : r_wr;
        n_rd  = i_pop  ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt + QCNT_W'(i_push) - QCNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];

endmodule
`default_nettype wire

/* rtl/prqf_back.sv */
// Back end: accumulates per-pair counts and sums, then judges the pair.
`default_nettype none
module prqf_back
    import prqf_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_q_valid,
    input  wire t_cls             i_q_data,
    output logic                  o_q_pop,
    input  wire logic [CFG_W-1:0] i_min_mean,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output t_out_beat             o_out_beat
);

    t_pair_stat r_acc, n_acc;
    t_pair_stat r_ev;
    logic       r_ev_valid;
    logic       r_out_valid;
    t_out_beat  r_out, n_out;
    logic       ev_adv, ev_free;
    logic       rej_fwd, rej_rev;

    assign ev_adv  = r_ev_valid && (!r_out_valid || !i_out_stall);
    assign ev_free = !r_ev_valid || ev_adv;
    assign o_q_pop = i_q_valid && (!i_q_data.last || ev_free);

    always_comb begin
        n_acc = r_acc;
        if (r_acc.len == LEN_W'(MAX_READ_LEN)) begin
            n_acc.ovf = 1'b1;
        end else begin
            n_acc.len = r_acc.len + 1'b1;
            for (int k = 0; k < NUM_SYM; k++) begin
                n_acc.fwd_cnt[k] = r_acc.fwd_cnt[k] + LEN_W'(i_q_data.fwd_sym[k]);
                n_acc.rev_cnt[k] = r_acc.rev_cnt[k] + LEN_W'(i_q_data.rev_sym[k]);
            end
            n_acc.fwd_sum = r_acc.fwd_sum
                + {{(SUM_W-QV_W){i_q_data.fwd_q[QV_W-1]}}, i_q_data.fwd_q};
            n_acc.rev_sum = r_acc.rev_sum
                + {{(SUM_W-QV_W){i_q_data.rev_q[QV_W-1]}}, i_q_data.rev_q};
            n_acc.fwd_dot = r_acc.fwd_dot | i_q_data.fwd_dot;
            n_acc.rev_dot = r_acc.rev_dot | i_q_data.rev_dot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (o_q_pop) begin
            r_acc <= i_q_data.last ? '0 : n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev_valid <= 1'b0;
        end else if (o_q_pop && i_q_data.last) begin
            r_ev_valid <= 1'b1;
        end else if (ev_adv) begin
            r_ev_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop && i_q_data.last) begin
            r_ev <= n_acc;
        end
    end

    // N limit: N > ceil(len/20)  <=>  20*N >= len + 20
    // symbol limit: c > floor(5*len/6)  <=>  6*c > 5*len
    function automatic logic read_bad(input logic [NUM_SYM-1:0][LEN_W-1:0] cnt,
                                      input logic signed [SUM_W-1:0] sum,
                                      input logic [LEN_W-1:0] len,
                                      input logic dot,
                                      input logic [CFG_W-1:0] cut);
        logic                    bad;
        logic [LEN_W+4:0]        n20;
        logic [LEN_W+4:0]        lim_n;
        logic [LEN_W+2:0]        len5;
        logic [LEN_W+CFG_W-1:0]  need;
        n20   = (LEN_W+5)'(cnt[SYM_N]) * (LEN_W+5)'(20);
        lim_n = (LEN_W+5)'(len) + (LEN_W+5)'(20);
        len5  = (LEN_W+3)'(len) * (LEN_W+3)'(5);
        need  = (LEN_W+CFG_W)'(cut) * (LEN_W+CFG_W)'(len);
        bad   = dot || (n20 >= lim_n)
                || (sum < $signed({{(SUM_W-LEN_W-CFG_W){1'b0}}, need}));
        for (int k = SYM_A; k < NUM_SYM; k++) begin
            if ((LEN_W+3)'(cnt[k]) * (LEN_W+3)'(6) > len5) begin
                bad = 1'b1;
            end
        end
        return bad;
    endfunction

    always_comb begin
        rej_fwd = read_bad(r_ev.fwd_cnt, r_ev.fwd_sum, r_ev.len, r_ev.fwd_dot, i_min_mean);
        rej_rev = read_bad(r_ev.rev_cnt, r_ev.rev_sum, r_ev.len, r_ev.rev_dot, i_min_mean);
        n_out.reject      = r_ev.ovf || rej_fwd || rej_rev;
        n_out.read_length = OUT_LEN_W'(r_ev.len);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ev_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ev_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

`ifndef SYNTHESIS
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_acc.len <= LEN_W'(MAX_READ_LEN))
        else $error("position count above maximum read length");

    a_last_loads_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_q_pop && i_q_data.last) |=> r_ev_valid)
        else $error("last position did not reach the judge stage");

    a_eval_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ev_valid && !ev_adv) |=> (r_ev_valid && $stable(r_ev)))
        else $error("blocked pair snapshot changed");

    a_acc_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_q_pop && i_q_data.last) |=> (r_acc.len == '0 && !r_acc.ovf))
        else $error("pair state not cleared after last position");
`endif

endmodule
`default_nettype wire

/* rtl/paired_read_quality_filter.sv */
// Top level of the paired read quality filter: register port, front end, queue, back end.
`default_nettype none
// One beat carries one base position of a read pair (forward and reverse base
// and quality). The block takes one position per cycle while the queue has room;
// o_in_stall rises when the four-entry queue between the input and the back end
// fills, as when a pair's last position waits for a busy judge stage. A pair's
// verdict (reject, read length) passes through the queue, the judge snapshot
// register and the output register, and the next pair may start on the cycle
// after its last position. Set the quality offset (byte address 0) and mean
// quality cut (byte address 4) only while no pair is in flight.
module paired_read_quality_filter
    import prqf_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire t_in_beat    i_in_beat,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_out_beat        o_out_beat,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [CFG_W-1:0] r_qual_offset;
    logic [CFG_W-1:0] r_min_mean;
    logic             cfg_wr;
    logic             q_full;
    logic             q_push;
    logic             q_pop;
    logic             q_valid;
    t_cls             front_cls;
    t_cls             q_data;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qual_offset <= QUAL_OFFSET_RST;
            r_min_mean    <= MIN_MEAN_RST;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_QUAL_OFFSET: r_qual_offset <= pwdata[CFG_W-1:0];
                REG_MIN_MEAN:    r_min_mean    <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_QUAL_OFFSET: prdata = {{(32-CFG_W){1'b0}}, r_qual_offset};
            REG_MIN_MEAN:    prdata = {{(32-CFG_W){1'b0}}, r_min_mean};
            default:         prdata = '0;
        endcase
    end

    assign o_in_stall = q_full;
    assign q_push     = i_in_valid && !q_full;

    prqf_front u_front (
        .i_beat        (i_in_beat),
        .i_qual_offset (r_qual_offset),
        .o_cls         (front_cls)
    );

    prqf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (front_cls),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    prqf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_data    (q_data),
        .o_q_pop     (q_pop),
        .i_min_mean  (r_min_mean),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_beat  (o_out_beat)
    );

endmodule
`default_nettype wire
